@@ hw/rtl/hbmt_pkg.sv @@
// shared types and constants for the heartbeat membership table
// no dependencies
package hbmt_pkg;

    localparam int MAX_MEMBERS = 32;
    localparam int SLOT_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

    localparam logic [1:0] OP_MERGE = 2'd0;
    localparam logic [1:0] OP_JOIN  = 2'd1;
    localparam logic [1:0] OP_ROUND = 2'd2;

    localparam logic [2:0] ST_UPDATED   = 3'd0;
    localparam logic [2:0] ST_UNCHANGED = 3'd1;
    localparam logic [2:0] ST_ADDED     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_DUP_JOIN  = 3'd4;
    localparam logic [2:0] ST_LIST      = 3'd5;
    localparam logic [2:0] ST_REMOVED   = 3'd6;

    localparam logic [1:0] CFG_FAIL_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_REMOVE_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_SELF_ID        = 2'd2;
    localparam logic [1:0] CFG_SELF_PORT      = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] member_id;
        logic [15:0] member_port;
        logic [31:0] heartbeat_in;
        logic [31:0] now;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_id;
        logic [15:0] out_port;
        logic [31:0] out_heartbeat;
        logic        list_empty;
        logic        last;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic              load_item;
        logic              clear_scan;   // reset slot pointer and found flags
        logic              scan_step;    // evaluate slot at pointer, advance
        logic              merge_write;  // apply merge at found or free slot
        logic              round_start;  // bump own heartbeat, stamp slot zero
        logic              remove_slot;  // clear slot at pointer
        logic [2:0]        emit_status;
        logic              emit_slot;    // emit entry at pointer (else merge/full/empty)
        logic              emit_empty;
        logic              emit_echo;    // echo input fields
        logic              emit_found;   // emit found slot contents
        logic              emit_last;
        logic              emit;
    } hbmt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       scan_done;   // pointer is at the last slot
        logic       hit;         // found flag from search
        logic       free_found;
        logic       hb_greater;
        logic       cur_match;
        logic       cur_stale;   // valid non-self slot past remove timeout
        logic       cur_live;    // valid slot within fail timeout
        logic       any_listed;  // some slot goes into the list
        logic       more_live;   // a listed slot lies above the pointer
    } hbmt_stat_t;

endpackage

@@ hw/rtl/hbmt_datapath.sv @@
// slot table, config registers, scan pointer and output register
// depends on hbmt_pkg
module hbmt_datapath
    import hbmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  in_word_t   in_word,
    input  hbmt_cmd_t  cmd,
    output hbmt_stat_t stat,
    output out_word_t  out_word
);

    logic [15:0] fail_timeout_reg;
    logic [15:0] remove_timeout_reg;
    logic [31:0] self_id_reg;
    logic [15:0] self_port_reg;

    in_word_t    item_reg;
    logic [MAX_MEMBERS-1:0] valid_reg;
    logic [31:0] id_mem   [MAX_MEMBERS];
    logic [15:0] port_mem [MAX_MEMBERS];
    logic [31:0] hb_reg   [MAX_MEMBERS];
    logic [31:0] stamp_reg[MAX_MEMBERS];
    logic [31:0] own_hb_reg;

    logic [SLOT_W-1:0] ptr_reg;
    logic [SLOT_W-1:0] found_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] free_reg;
    logic              free_found_reg;
    logic [MAX_MEMBERS-1:0] live_reg;
    out_word_t         out_reg;

    logic [31:0] cur_id;
    logic [15:0] cur_port;
    logic [31:0] cur_age;
    logic [31:0] f_id;
    logic [15:0] f_port;
    logic [MAX_MEMBERS-1:0] live_above;

    always_comb
    begin
        cur_id     = (ptr_reg == '0) ? self_id_reg : id_mem[ptr_reg];
        cur_port   = (ptr_reg == '0) ? self_port_reg : port_mem[ptr_reg];
        cur_age    = item_reg.now - stamp_reg[ptr_reg];
        f_id       = (found_reg == '0) ? self_id_reg : id_mem[found_reg];
        f_port     = (found_reg == '0) ? self_port_reg : port_mem[found_reg];
        live_above = live_reg >> ptr_reg;
    end

    assign stat.opcode     = item_reg.opcode;
    assign stat.scan_done  = (ptr_reg == SLOT_W'(MAX_MEMBERS - 1));
    assign stat.hit        = hit_reg;
    assign stat.free_found = free_found_reg;
    assign stat.hb_greater = item_reg.heartbeat_in > hb_reg[found_reg];
    assign stat.cur_match  = valid_reg[ptr_reg] && cur_id == item_reg.member_id
                             && cur_port == item_reg.member_port;
    assign stat.cur_stale  = valid_reg[ptr_reg] && ptr_reg != '0
                             && cur_age > {16'd0, remove_timeout_reg};
    assign stat.cur_live   = valid_reg[ptr_reg] && cur_age <= {16'd0, fail_timeout_reg};
    assign stat.any_listed = |live_reg;
    assign stat.more_live  = |live_above[MAX_MEMBERS-1:1];

    assign out_word = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_timeout_reg   <= 16'd5;
            remove_timeout_reg <= 16'd20;
            self_id_reg        <= 32'd1;
            self_port_reg      <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FAIL_TIMEOUT:   fail_timeout_reg   <= cfg_data[15:0];
                CFG_REMOVE_TIMEOUT: remove_timeout_reg <= cfg_data[15:0];
                CFG_SELF_ID:        self_id_reg        <= cfg_data;
                CFG_SELF_PORT:      self_port_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= MAX_MEMBERS'(1);
            own_hb_reg     <= '0;
            ptr_reg        <= '0;
            found_reg      <= '0;
            hit_reg        <= 1'b0;
            free_reg       <= '0;
            free_found_reg <= 1'b0;
            live_reg       <= '0;
            for (int i = 0; i < MAX_MEMBERS; i++)
            begin
                hb_reg[i]    <= '0;
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clear_scan)
            begin
                ptr_reg        <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (stat.cur_match && !hit_reg)
                begin
                    hit_reg   <= 1'b1;
                    found_reg <= ptr_reg;
                end
                if (!valid_reg[ptr_reg] && ptr_reg != '0 && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_reg       <= ptr_reg;
                end
                if (!stat.scan_done)
                    ptr_reg <= ptr_reg + 1'b1;
            end
            // remember which slots the following list will report
            if (cmd.scan_step)
                live_reg[ptr_reg] <= (item_reg.opcode == OP_ROUND)
                                     ? (stat.cur_live && !stat.cur_stale) : stat.cur_live;
            if (cmd.remove_slot)
                valid_reg[ptr_reg] <= 1'b0;
            if (cmd.merge_write)
            begin
                if (hit_reg)
                begin
                    if (stat.hb_greater)
                    begin
                        hb_reg[found_reg]    <= item_reg.heartbeat_in;
                        stamp_reg[found_reg] <= item_reg.now;
                    end
                end
                else if (free_found_reg)
                begin
                    valid_reg[free_reg] <= 1'b1;
                    hb_reg[free_reg]    <= item_reg.heartbeat_in;
                    stamp_reg[free_reg] <= item_reg.now;
                end
            end
            if (cmd.round_start)
            begin
                hb_reg[0]    <= (own_hb_reg == '1) ? own_hb_reg : own_hb_reg + 1'b1;
                own_hb_reg   <= (own_hb_reg == '1) ? own_hb_reg : own_hb_reg + 1'b1;
                stamp_reg[0] <= item_reg.now;
            end
        end
    end

    // id and port stores have no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_word;
        if (cmd.merge_write && !hit_reg && free_found_reg)
        begin
            id_mem[free_reg]   <= item_reg.member_id;
            port_mem[free_reg] <= item_reg.member_port;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.status     <= cmd.emit_status;
            out_reg.list_empty <= cmd.emit_empty;
            out_reg.last       <= cmd.emit_last;
            if (cmd.emit_empty)
            begin
                out_reg.out_id        <= '0;
                out_reg.out_port      <= '0;
                out_reg.out_heartbeat <= '0;
            end
            else if (cmd.emit_slot)
            begin
                out_reg.out_id        <= cur_id;
                out_reg.out_port      <= cur_port;
                out_reg.out_heartbeat <= hb_reg[ptr_reg];
            end
            else if (cmd.emit_echo)
            begin
                out_reg.out_id        <= item_reg.member_id;
                out_reg.out_port      <= item_reg.member_port;
                out_reg.out_heartbeat <= item_reg.heartbeat_in;
            end
            else
            begin
                // found slot, after any update applied in the same cycle
                out_reg.out_id   <= f_id;
                out_reg.out_port <= f_port;
                out_reg.out_heartbeat <= (cmd.emit_found && stat.hb_greater
                                          && cmd.emit_status == ST_UPDATED)
                                         ? item_reg.heartbeat_in : hb_reg[found_reg];
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) valid_reg[0])
        else $error("slot zero lost its valid bit");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove_slot |-> ptr_reg != '0)
        else $error("self slot removed");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round_start |=> own_hb_reg >= $past(own_hb_reg))
        else $error("own heartbeat went down");

endmodule

@@ hw/rtl/hbmt_ctrl.sv @@
// sequencer for merge, join and round items
// depends on hbmt_pkg
module hbmt_ctrl
    import hbmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  hbmt_stat_t stat,
    output hbmt_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_REMOVE = 3'd3;
    localparam logic [2:0] S_LIST   = 3'd4;
    localparam logic [2:0] S_EMPTY  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_emit;
    logic       accept;

    assign out_valid = out_valid_reg;
    assign can_emit  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item  = 1'b1;
                    cmd.clear_scan = 1'b1;
                    state_next     = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                case (stat.opcode)
                    OP_MERGE, OP_JOIN:
                    begin
                        cmd.scan_step = 1'b1;
                        if (stat.scan_done)
                            state_next = S_DECIDE;
                    end
                    OP_ROUND:
                    begin
                        cmd.round_start = 1'b1;
                        cmd.clear_scan  = 1'b1;
                        state_next      = S_REMOVE;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_DECIDE:
            begin
                if (stat.opcode == OP_JOIN && !stat.hit)
                begin
                    cmd.clear_scan = 1'b1;
                    state_next     = S_LIST;
                end
                else if (can_emit)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_last  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (stat.opcode == OP_JOIN)
                    begin
                        cmd.emit_status = ST_DUP_JOIN;
                        cmd.emit_found  = 1'b1;
                    end
                    else if (stat.hit)
                    begin
                        cmd.merge_write = 1'b1;
                        cmd.emit_found  = 1'b1;
                        cmd.emit_status = stat.hb_greater ? ST_UPDATED : ST_UNCHANGED;
                    end
                    else if (stat.free_found)
                    begin
                        cmd.merge_write = 1'b1;
                        cmd.emit_echo   = 1'b1;
                        cmd.emit_status = ST_ADDED;
                    end
                    else
                    begin
                        cmd.emit_echo   = 1'b1;
                        cmd.emit_status = ST_FULL;
                    end
                end
            end
            S_REMOVE:
            begin
                if (stat.cur_stale)
                begin
                    if (can_emit)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_slot   = 1'b1;
                        cmd.emit_status = ST_REMOVED;
                        cmd.remove_slot = 1'b1;
                        cmd.scan_step   = 1'b1;
                        out_valid_next  = 1'b1;
                    end
                end
                else
                    cmd.scan_step = 1'b1;
                if ((!stat.cur_stale || can_emit) && stat.scan_done)
                begin
                    cmd.clear_scan = 1'b1;
                    state_next     = S_LIST;
                end
            end
            S_LIST:
            begin
                if (stat.cur_live)
                begin
                    if (can_emit)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_slot   = 1'b1;
                        cmd.emit_status = ST_LIST;
                        cmd.emit_last   = !stat.more_live;
                        cmd.scan_step   = 1'b1;
                        out_valid_next  = 1'b1;
                        if (!stat.more_live)
                            state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_done)
                        state_next = stat.any_listed ? S_IDLE : S_EMPTY;
                end
            end
            S_EMPTY:
            begin
                if (can_emit)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_empty  = 1'b1;
                    cmd.emit_status = ST_LIST;
                    cmd.emit_last   = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> can_emit)
        else $error("result overwritten while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> state_reg == S_IDLE)
        else $error("item taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.merge_write || cmd.remove_slot) |-> cmd.emit)
        else $error("table changed without a result");

endmodule

@@ hw/rtl/heartbeat_membership_table.sv @@
// top level of the heartbeat membership table
// depends on hbmt_pkg, hbmt_ctrl, hbmt_datapath
//
// input words carry an opcode: merge, join request or heartbeat round.
// a word is taken when in_valid is high and in_stall low; in_stall is high
// while an item is in work, so one item is handled at a time.
// results leave through a registered output: out_valid with out_stall; the
// final result of an item has last set.
// merge and duplicate join: one slot scan, then a decision state.
// join listing: search scan and decision, then one list scan.
// round: one removal scan and one list scan.
// the slot scan (one slot a cycle through a shared compare) sets the rate;
// a stalled output holds the scan at a slot with a result until the word is taken.
// reset: slot zero valid with heartbeat and stamp zero, all other slots free,
// registers at fail_timeout 5, remove_timeout 20, self_id 1, self_port 0.
// config writes (cfg_we, cfg_index, cfg_data) are for idle times only.
module heartbeat_membership_table
    import hbmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_data
);

    hbmt_cmd_t  cmd;
    hbmt_stat_t stat;

    hbmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    hbmt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (out_data)
    );

endmodule
